>>> design/sdiocf_pkg.sv
// Shared constants for the SDIO I/O command formatter.
`timescale 1ns / 1ps

package sdiocf_pkg;

    // Default sizing
    localparam int DEF_FUNCTION_COUNT     = 8;
    localparam int DEF_MAX_TRANSFER_BYTES = 512;

    // Field widths fixed by the request format
    localparam int FN_BITS   = 3;
    localparam int ADDR_BITS = 17;
    localparam int LEN_BITS  = 10;
    localparam int BSC_BITS  = 26;

    // Command indexes
    localparam logic [7:0] CMD_IO_RW_DIRECT   = 8'd52;
    localparam logic [7:0] CMD_IO_RW_EXTENDED = 8'd53;

    // Command word flags
    localparam logic [31:0] RESP_48            = 32'h0002_0000;
    localparam logic [31:0] CRC_CHECK          = 32'h0008_0000;
    localparam logic [31:0] INDEX_CHECK        = 32'h0010_0000;
    localparam logic [31:0] HAS_DATA           = 32'h0020_0000;
    localparam logic [31:0] BLOCK_COUNT_ENABLE = 32'h0000_0002;
    localparam logic [31:0] DIR_READ           = 32'h0000_0010;
    localparam logic [31:0] MULTI_BLOCK        = 32'h0000_0020;

    // FBR block-size byte offsets inside each function's 256-byte window
    localparam logic [7:0] FBR_SIZE_LO = 8'h10;
    localparam logic [7:0] FBR_SIZE_HI = 8'h11;

    // Request operation codes
    localparam logic OP_DIRECT   = 1'b0;
    localparam logic OP_EXTENDED = 1'b1;

    // Error codes
    localparam logic ERR_NONE    = 1'b0;
    localparam logic ERR_INVALID = 1'b1;

endpackage

>>> design/sdio_io_command_formatter.sv
// SDIO CMD52/CMD53 command, argument and block word formatter with block-size shadow.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ------------------------------------------------
// in       sink       in_valid / in_stall  operation, write_access, function_number,
//                                          register_address, write_byte, byte_length,
//                                          addr_increment
// out      source     out_valid/out_stall  error_code, command_word, argument_word,
//                                          block_size_count
//
// Timing: a CMD52 or a rejected request is formed in the accept cycle, so its beat
//   shows in the cycle after accept. A CMD53 whose shadowed block size is zero or larger
//   than the length also finishes at once. Otherwise a restoring divider takes one quotient
//   bit per cycle in S_DIVIDE, then S_FINISH forms the words and S_HOLD shows the beat.
// One item at a time: in_stall is high from accept until the result beat is taken.
// Reset clears the block-size shadow of every function and empties the pipeline.
// out_stall holds the result registers unchanged until the beat is taken.

module sdio_io_command_formatter #(
    parameter int FUNCTION_COUNT     = sdiocf_pkg::DEF_FUNCTION_COUNT,
    parameter int MAX_TRANSFER_BYTES = sdiocf_pkg::DEF_MAX_TRANSFER_BYTES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic                                 write_access,
    input  logic [sdiocf_pkg::FN_BITS-1:0]       function_number,
    input  logic [sdiocf_pkg::ADDR_BITS-1:0]     register_address,
    input  logic [7:0]                           write_byte,
    input  logic [sdiocf_pkg::LEN_BITS-1:0]      byte_length,
    input  logic                                 addr_increment,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 error_code,
    output logic [31:0]                          command_word,
    output logic [31:0]                          argument_word,
    output logic [sdiocf_pkg::BSC_BITS-1:0]      block_size_count
);

    import sdiocf_pkg::*;

    // Shadow index width; at least one bit even for a single function
    localparam int IDX_W = (FUNCTION_COUNT > 1) ? $clog2(FUNCTION_COUNT) : 1;
    localparam logic [31:0] FN_LIMIT = 32'(FUNCTION_COUNT);
    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_TRANSFER_BYTES);
    localparam logic [3:0] LAST_STEP = 4'(LEN_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_FINISH,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic [31:0]         cmd;
        logic [31:0]         arg;
        logic [BSC_BITS-1:0] bsc;
    } words_t;

    // Build the CMD53 words; in byte mode bsize carries the length and bcount is one
    function automatic words_t ext_words(
        input logic                 wr,
        input logic [FN_BITS-1:0]   fn,
        input logic [ADDR_BITS-1:0] addr,
        input logic                 inc,
        input logic                 blk,
        input logic [LEN_BITS-1:0]  bcount,
        input logic [LEN_BITS-1:0]  bsize
    );
        words_t w;
        logic [8:0] cnt9;
        cnt9  = blk ? bcount[8:0] : bsize[8:0];
        w.cmd = {CMD_IO_RW_EXTENDED, 24'd0} | RESP_48 | CRC_CHECK | INDEX_CHECK
                | HAS_DATA | BLOCK_COUNT_ENABLE
                | (wr ? 32'd0 : DIR_READ)
                | ((bcount > LEN_BITS'(1)) ? MULTI_BLOCK : 32'd0);
        w.arg = {wr, fn, blk, inc, addr, cnt9};
        w.bsc = {bcount, 6'd0, bsize};
        return w;
    endfunction

    state_t                state_reg, state_next;
    logic [15:0]           shadow_reg [FUNCTION_COUNT];
    logic [15:0]           shadow_next [FUNCTION_COUNT];

    // Latched CMD53 request
    logic                  wr_reg, wr_next;
    logic [FN_BITS-1:0]    fn_reg, fn_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic                  inc_reg, inc_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;

    // Divider registers
    logic [LEN_BITS-1:0]   dvs_reg, dvs_next;
    logic [LEN_BITS-1:0]   dvd_reg, dvd_next;
    logic [LEN_BITS-1:0]   rem_reg, rem_next;
    logic [LEN_BITS-1:0]   quo_reg, quo_next;
    logic [3:0]            step_reg, step_next;

    // Result registers
    logic                  out_valid_reg, out_valid_next;
    logic                  err_reg, err_next;
    logic [31:0]           cmd_reg, cmd_next;
    logic [31:0]           arg_reg, arg_next;
    logic [BSC_BITS-1:0]   bsc_reg, bsc_next;

    logic                  accept;
    logic                  fn_in_range;
    logic                  target_ok;
    logic [IDX_W-1:0]      fn_idx;
    logic [IDX_W-1:0]      target_idx;
    logic [15:0]           cur_size;
    logic                  ext_bad;
    logic                  size_fits;
    logic [LEN_BITS:0]     r_shift;
    logic [LEN_BITS:0]     r_diff;
    logic                  r_ge;
    logic                  fin_blk;
    words_t                byte_words;
    words_t                fin_words;

    assign accept      = in_valid && !in_stall;
    assign fn_in_range = ({29'd0, function_number} < FN_LIMIT);
    assign fn_idx      = IDX_W'(function_number);
    assign target_idx  = IDX_W'(register_address[ADDR_BITS-1:8]);
    assign target_ok   = (register_address[ADDR_BITS-1:8] != '0)
                         && ({23'd0, register_address[ADDR_BITS-1:8]} < FN_LIMIT);
    assign cur_size    = shadow_reg[fn_idx];
    assign ext_bad     = (function_number == '0) || !fn_in_range
                         || (byte_length == '0) || (byte_length > MAX_LEN);
    // Block mode is only possible when the shadowed size is nonzero and within the length
    assign size_fits   = (cur_size != 16'd0) && (cur_size <= {6'd0, byte_length});

    // One restoring-division step: bring down the next dividend bit, try a subtract
    assign r_shift = {rem_reg, dvd_reg[LEN_BITS-1]};
    assign r_diff  = r_shift - {1'b0, dvs_reg};
    assign r_ge    = (r_shift >= {1'b0, dvs_reg});

    assign fin_blk    = (rem_reg == '0);
    assign byte_words = ext_words(write_access, function_number, register_address,
                                  addr_increment, 1'b0, LEN_BITS'(1), byte_length);
    assign fin_words  = ext_words(wr_reg, fn_reg, addr_reg, inc_reg, fin_blk,
                                  fin_blk ? quo_reg : LEN_BITS'(1),
                                  fin_blk ? dvs_reg : len_reg);

    always_comb
    begin
        state_next     = state_reg;
        shadow_next    = shadow_reg;
        wr_next        = wr_reg;
        fn_next        = fn_reg;
        addr_next      = addr_reg;
        inc_next       = inc_reg;
        len_next       = len_reg;
        dvs_next       = dvs_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        err_next       = err_reg;
        cmd_next       = cmd_reg;
        arg_next       = arg_reg;
        bsc_next       = bsc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Default to a rejected request; overwrite below when it forms
                    err_next       = ERR_INVALID;
                    cmd_next       = '0;
                    arg_next       = '0;
                    bsc_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_HOLD;
                    if (operation == OP_DIRECT)
                    begin
                        if (fn_in_range)
                        begin
                            err_next = ERR_NONE;
                            cmd_next = {CMD_IO_RW_DIRECT, 24'd0} | RESP_48 | CRC_CHECK
                                       | INDEX_CHECK;
                            arg_next = {write_access, function_number, 2'b00,
                                        register_address, 1'b0, write_byte};
                            // Learn FBR block-size bytes as the write is issued
                            if (write_access && function_number == '0 && target_ok)
                            begin
                                if (register_address[7:0] == FBR_SIZE_LO)
                                    shadow_next[target_idx][7:0] = write_byte;
                                else if (register_address[7:0] == FBR_SIZE_HI)
                                    shadow_next[target_idx][15:8] = write_byte;
                            end
                        end
                    end
                    else if (!ext_bad)
                    begin
                        if (size_fits)
                        begin
                            // Divide length by the shadowed size
                            out_valid_next = 1'b0;
                            state_next     = S_DIVIDE;
                            wr_next        = write_access;
                            fn_next        = function_number;
                            addr_next      = register_address;
                            inc_next       = addr_increment;
                            len_next       = byte_length;
                            dvs_next       = cur_size[LEN_BITS-1:0];
                            dvd_next       = byte_length;
                            rem_next       = '0;
                            quo_next       = '0;
                            step_next      = '0;
                        end
                        else
                        begin
                            err_next = ERR_NONE;
                            cmd_next = byte_words.cmd;
                            arg_next = byte_words.arg;
                            bsc_next = byte_words.bsc;
                        end
                    end
                end
            end

            S_DIVIDE:
            begin
                rem_next  = r_ge ? r_diff[LEN_BITS-1:0] : r_shift[LEN_BITS-1:0];
                quo_next  = {quo_reg[LEN_BITS-2:0], r_ge};
                dvd_next  = {dvd_reg[LEN_BITS-2:0], 1'b0};
                step_next = step_reg + 4'd1;
                if (step_reg == LAST_STEP)
                    state_next = S_FINISH;
            end

            S_FINISH:
            begin
                err_next       = ERR_NONE;
                cmd_next       = fin_words.cmd;
                arg_next       = fin_words.arg;
                bsc_next       = fin_words.bsc;
                out_valid_next = 1'b1;
                state_next     = S_HOLD;
            end

            S_HOLD:
            begin
                // Drop the beat once taken
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            for (int i = 0; i < FUNCTION_COUNT; i++)
                shadow_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            shadow_reg    <= shadow_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        wr_reg   <= wr_next;
        fn_reg   <= fn_next;
        addr_reg <= addr_next;
        inc_reg  <= inc_next;
        len_reg  <= len_next;
        dvs_reg  <= dvs_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        err_reg  <= err_next;
        cmd_reg  <= cmd_next;
        arg_reg  <= arg_next;
        bsc_reg  <= bsc_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign error_code       = err_reg;
    assign command_word     = cmd_reg;
    assign argument_word    = arg_reg;
    assign block_size_count = bsc_reg;

    // An accepted beat always blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // No new request while a result is pending
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // A rejected request carries all-zero words
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code == ERR_INVALID) |->
        (command_word == '0 && argument_word == '0 && block_size_count == '0))
        else $error("error result carries nonzero words");

    // A direct access has no block word
    a_direct_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code == ERR_NONE && command_word[31:24] == CMD_IO_RW_DIRECT)
        |-> (block_size_count == '0))
        else $error("CMD52 result with block word");

    // The divider only runs while the output is empty
    a_divide_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE || state_reg == S_FINISH) |-> !out_valid)
        else $error("result shown during divide");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the SDIO CMD52/CMD53 command formatter.
`timescale 1ns / 1ps

module testbench;

    import sdiocf_pkg::*;

    localparam int FN_COUNT  = DEF_FUNCTION_COUNT;
    localparam int MAX_BYTES = DEF_MAX_TRANSFER_BYTES;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1000;
    // Idle for longer than the divider path takes before the verdict.
    localparam int SETTLE_CYCLES = 30;

    // One request beat plus a bench-only flag: hold it back until the
    // result store is empty.
    typedef struct packed {
        logic                 op;
        logic                 wr;
        logic [FN_BITS-1:0]   fn;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           data;
        logic [LEN_BITS-1:0]  len;
        logic                 inc;
        logic                 hold_off;
    } request_t;

    typedef struct packed {
        logic                err;
        logic [31:0]         cmd;
        logic [31:0]         arg;
        logic [BSC_BITS-1:0] bsc;
    } result_t;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // Block inputs start at known values.
    logic                 in_valid          = 1'b0;
    logic                 operation         = OP_DIRECT;
    logic                 write_access      = 1'b0;
    logic [FN_BITS-1:0]   function_number   = '0;
    logic [ADDR_BITS-1:0] register_address  = '0;
    logic [7:0]           write_byte        = '0;
    logic [LEN_BITS-1:0]  byte_length       = '0;
    logic                 addr_increment    = 1'b0;
    logic                 out_stall         = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 error_code;
    logic [31:0]          command_word;
    logic [31:0]          argument_word;
    logic [BSC_BITS-1:0]  block_size_count;

    sdio_io_command_formatter DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .write_access      (write_access),
        .function_number   (function_number),
        .register_address  (register_address),
        .write_byte        (write_byte),
        .byte_length       (byte_length),
        .addr_increment    (addr_increment),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .error_code        (error_code),
        .command_word      (command_word),
        .argument_word     (argument_word),
        .block_size_count  (block_size_count)
    );

    request_t    request_queue[$];
    result_t     expected_results[$];
    logic [15:0] block_size_shadow [FN_COUNT];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        quiet       = 1'b0;

    // Predict the result of one request and track the block-size shadow
    // exactly as the block learns it from CMD52 writes to function 0.
    function automatic result_t format_request(request_t rq);
        result_t     res;
        logic [15:0] bsize;
        logic [15:0] bcount;
        logic [8:0]  target;
        logic        blk;
        res     = '0;
        res.err = ERR_INVALID;
        if (rq.op == OP_DIRECT)
        begin
            if (int'(rq.fn) < FN_COUNT)
            begin
                res.err = ERR_NONE;
                res.cmd = {CMD_IO_RW_DIRECT, 24'h0} | RESP_48 | CRC_CHECK | INDEX_CHECK;
                res.arg = {rq.wr, rq.fn, 2'b00, rq.addr, 1'b0, rq.data};
                // Update the shadow on issue; only FBR windows of real functions count.
                target = rq.addr[16:8];
                if (rq.wr && rq.fn == '0 && target != '0 && int'(target) < FN_COUNT)
                begin
                    if (rq.addr[7:0] == FBR_SIZE_LO)
                        block_size_shadow[target][7:0] = rq.data;
                    else if (rq.addr[7:0] == FBR_SIZE_HI)
                        block_size_shadow[target][15:8] = rq.data;
                end
            end
        end
        else if (rq.fn != '0 && int'(rq.fn) < FN_COUNT && rq.len != '0 &&
                 int'(rq.len) <= MAX_BYTES)
        begin
            bsize = block_size_shadow[rq.fn];
            blk   = 1'b0;
            if (bsize != '0 && int'(rq.len) >= int'(bsize) &&
                (int'(rq.len) % int'(bsize)) == 0)
            begin
                blk    = 1'b1;
                bcount = 16'(int'(rq.len) / int'(bsize));
            end
            else
            begin
                bsize  = 16'(rq.len);
                bcount = 16'd1;
            end
            res.err = ERR_NONE;
            res.cmd = {CMD_IO_RW_EXTENDED, 24'h0} | RESP_48 | CRC_CHECK | INDEX_CHECK |
                      HAS_DATA | BLOCK_COUNT_ENABLE;
            if (!rq.wr)
                res.cmd = res.cmd | DIR_READ;
            if (bcount > 16'd1)
                res.cmd = res.cmd | MULTI_BLOCK;
            // A count of 512 drops out of the 9-bit field as zero.
            res.arg = {rq.wr, rq.fn, blk, rq.inc, rq.addr,
                       blk ? bcount[8:0] : bsize[8:0]};
            res.bsc = {bcount[9:0], bsize};
        end
        return res;
    endfunction

    function automatic request_t direct_req(logic wr, logic [FN_BITS-1:0] fn,
                                            logic [ADDR_BITS-1:0] addr, logic [7:0] data);
        request_t rq;
        rq.op       = OP_DIRECT;
        rq.wr       = wr;
        rq.fn       = fn;
        rq.addr     = addr;
        rq.data     = data;
        rq.len      = LEN_BITS'($urandom);
        rq.inc      = 1'($urandom);
        rq.hold_off = 1'b0;
        return rq;
    endfunction

    function automatic request_t extended_req(logic wr, logic [FN_BITS-1:0] fn,
                                              logic [ADDR_BITS-1:0] addr,
                                              logic [LEN_BITS-1:0] len, logic inc);
        request_t rq;
        rq.op       = OP_EXTENDED;
        rq.wr       = wr;
        rq.fn       = fn;
        rq.addr     = addr;
        rq.data     = 8'($urandom);
        rq.len      = len;
        rq.inc      = inc;
        rq.hold_off = 1'b0;
        return rq;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Cycle counter; also flip between idling and back-to-back stretches.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 400 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
    end

    // Request driver: predict each accepted beat, then present the next one.
    request_t cur_req;
    int       in_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(format_request(cur_req));
            // Advance only when the slot is empty or its beat was just taken.
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0 &&
                         !(request_queue[0].hold_off &&
                           (expected_results.size() > 0 || (in_valid && !in_stall))))
                begin
                    cur_req = request_queue.pop_front();
                    operation         <= cur_req.op;
                    write_access      <= cur_req.wr;
                    function_number   <= cur_req.fn;
                    register_address  <= cur_req.addr;
                    write_byte        <= cur_req.data;
                    byte_length       <= cur_req.len;
                    addr_increment    <= cur_req.inc;
                    in_valid          <= 1'b1;
                    in_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each taken beat field by field, then pick the
    // next stall value.
    result_t exp_res;
    int      stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected");
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (error_code !== exp_res.err)
                        report_mismatch($sformatf("error_code got %0b want %0b",
                                                  error_code, exp_res.err));
                    if (command_word !== exp_res.cmd)
                        report_mismatch($sformatf("command_word got %h want %h",
                                                  command_word, exp_res.cmd));
                    if (argument_word !== exp_res.arg)
                        report_mismatch($sformatf("argument_word got %h want %h",
                                                  argument_word, exp_res.arg));
                    if (block_size_count !== exp_res.bsc)
                        report_mismatch($sformatf("block_size_count got %h want %h",
                                                  block_size_count, exp_res.bsc));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Timeout.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        request_t    rq;
        int          fn_sel;
        int          bsize_sel;
        int          len_sel;
        int          n_ext;
        int          roll;
        int          added;
        int          sizes [12];

        sizes = '{1, 2, 3, 4, 8, 16, 32, 64, 100, 128, 256, 512};
        foreach (block_size_shadow[i])
            block_size_shadow[i] = '0;

        // Directed part: plain CMD52 and field extremes.
        request_queue.push_back(direct_req(1'b0, 3'd0, 17'h00000, 8'h00));
        request_queue.push_back(direct_req(1'b1, 3'd7, 17'h1FFFF, 8'hFF));
        // CMD53 with no block size learned yet: byte mode.
        request_queue.push_back(extended_req(1'b1, 3'd1, 17'h00400, 10'd8, 1'b1));
        // Learn block size 8 for function 1, then block mode, single and multi.
        request_queue.push_back(direct_req(1'b1, 3'd0, 17'h00110, 8'h08));
        request_queue.push_back(extended_req(1'b1, 3'd1, 17'h00020, 10'd64, 1'b1));
        request_queue.push_back(extended_req(1'b0, 3'd1, 17'h00020, 10'd8, 1'b0));
        // Length not a multiple, and length below the block size: byte mode.
        request_queue.push_back(extended_req(1'b0, 3'd1, 17'h1FFFF, 10'd12, 1'b1));
        request_queue.push_back(extended_req(1'b1, 3'd1, 17'h00000, 10'd4, 1'b0));
        // High byte: size 520, larger than any legal length; 512 bytes encodes as 0.
        request_queue.push_back(direct_req(1'b1, 3'd0, 17'h00111, 8'h02));
        request_queue.push_back(extended_req(1'b1, 3'd1, 17'h00100, 10'd512, 1'b1));
        // Size 1: 512 blocks, count field wraps to zero.
        request_queue.push_back(direct_req(1'b1, 3'd0, 17'h00110, 8'h01));
        request_queue.push_back(direct_req(1'b1, 3'd0, 17'h00111, 8'h00));
        rq = extended_req(1'b0, 3'd1, 17'h1FFFF, 10'd512, 1'b0);
        rq.hold_off = 1'b1;
        request_queue.push_back(rq);
        // Reads, out-of-range FBR windows, other offsets and other functions
        // must all leave the shadow alone.
        request_queue.push_back(direct_req(1'b0, 3'd0, 17'h00110, 8'h40));
        request_queue.push_back(direct_req(1'b1, 3'd0, 17'h00010, 8'h20));
        request_queue.push_back(direct_req(1'b1, 3'd0, 17'h00810, 8'h20));
        request_queue.push_back(direct_req(1'b1, 3'd0, 17'h1FF11, 8'h20));
        request_queue.push_back(direct_req(1'b1, 3'd0, 17'h00112, 8'h20));
        request_queue.push_back(direct_req(1'b1, 3'd1, 17'h00110, 8'h20));
        request_queue.push_back(extended_req(1'b1, 3'd1, 17'h00003, 10'd2, 1'b1));
        // Invalid requests: function 0, zero length, over-long lengths.
        request_queue.push_back(extended_req(1'b1, 3'd0, 17'h00010, 10'd8, 1'b1));
        request_queue.push_back(extended_req(1'b0, 3'd2, 17'h00010, 10'd0, 1'b0));
        request_queue.push_back(extended_req(1'b1, 3'd2, 17'h00010, 10'd513, 1'b1));
        request_queue.push_back(extended_req(1'b0, 3'd2, 17'h1FFFF, 10'd1023, 1'b1));
        // Highest function, full length, no size learned.
        request_queue.push_back(extended_req(1'b1, 3'd7, 17'h00000, 10'd512, 1'b1));

        // Random part: mostly "learn a size, then transfer" sequences with
        // random content; the rest is unconstrained noise.
        added = 0;
        while (added < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                fn_sel = $urandom_range(1, FN_COUNT - 1);
                roll   = $urandom_range(0, 99);
                if (roll < 75)
                    bsize_sel = sizes[$urandom_range(0, 11)];
                else if (roll < 90)
                    bsize_sel = $urandom_range(1, 600);
                else
                    bsize_sel = $urandom_range(0, 65535);
                request_queue.push_back(direct_req(1'b1, 3'd0,
                    {9'(fn_sel), FBR_SIZE_LO}, 8'(bsize_sel)));
                added++;
                // Sometimes leave the high byte as it was.
                if ($urandom_range(0, 3) != 0)
                begin
                    request_queue.push_back(direct_req(1'b1, 3'd0,
                        {9'(fn_sel), FBR_SIZE_HI}, 8'(bsize_sel >> 8)));
                    added++;
                end
                n_ext = $urandom_range(1, 4);
                repeat (n_ext)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55 && bsize_sel >= 1 && bsize_sel <= MAX_BYTES)
                        len_sel = bsize_sel * $urandom_range(1, MAX_BYTES / bsize_sel);
                    else if (roll < 93)
                        len_sel = $urandom_range(1, MAX_BYTES);
                    else
                        len_sel = $urandom_range(0, 1023);
                    request_queue.push_back(extended_req(1'($urandom), 3'(fn_sel),
                        17'($urandom), 10'(len_sel), 1'($urandom)));
                    added++;
                end
            end
            else
            begin
                rq.op       = 1'($urandom);
                rq.wr       = 1'($urandom);
                rq.fn       = FN_BITS'($urandom);
                rq.addr     = ADDR_BITS'($urandom);
                rq.data     = 8'($urandom);
                rq.len      = LEN_BITS'($urandom);
                rq.inc      = 1'($urandom);
                rq.hold_off = 1'b0;
                request_queue.push_back(rq);
                added++;
            end
            // Now and then drain the block completely before the next beat.
            if ($urandom_range(0, 49) == 0)
                request_queue[request_queue.size() - 1].hold_off = 1'b1;
        end

        // Release reset.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every beat is sent and every result has come back.
        do
            @(posedge clk);
        while (request_queue.size() > 0 || in_valid || expected_results.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
